/* design/sptt_pkg.sv */
// Package for the swing point trend tracker: widths, defaults and the
// trend event type shared by the update logic, the trend counter and the top.
// No dependencies.
package sptt_pkg;

    // Default widths of the sample value and the trend counter.
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int TREND_WIDTH_DEF = 16;

    // Width of the minimum amplitude register.
    localparam int AMP_WIDTH = 31;

    // Number of swing points held and the width of their count.
    localparam int MAX_POINTS = 3;
    localparam int CNT_WIDTH  = 2;

    // Point counts with a meaning of their own.
    localparam logic [CNT_WIDTH-1:0] CNT_EMPTY = 2'd0;
    localparam logic [CNT_WIDTH-1:0] CNT_ONE   = 2'd1;
    localparam logic [CNT_WIDTH-1:0] CNT_PAIR  = 2'd2;
    localparam logic [CNT_WIDTH-1:0] CNT_FULL  = 2'd3;

    // Trend movement caused by one item: none, or one or two steps up or down.
    typedef struct packed {
        logic valid;
        logic dir_up;
        logic double_step;
    } trend_evt_t;

endpackage

/* design/sptt_update.sv */
// Next-state logic of the swing point store for one sample.
// Depends on sptt_pkg.
module sptt_update #(
    parameter int VALUE_WIDTH = sptt_pkg::VALUE_WIDTH_DEF
) (
    input  logic signed [VALUE_WIDTH-1:0]         sample_i,
    input  logic [sptt_pkg::AMP_WIDTH-1:0]        min_amp_i,
    input  logic [sptt_pkg::CNT_WIDTH-1:0]        count_i,
    input  logic signed [VALUE_WIDTH-1:0]         pts_i [sptt_pkg::MAX_POINTS],
    output logic [sptt_pkg::CNT_WIDTH-1:0]        count_o,
    output logic signed [VALUE_WIDTH-1:0]         pts_o [sptt_pkg::MAX_POINTS],
    output sptt_pkg::trend_evt_t                  evt_o
);
    import sptt_pkg::*;

    // Differences need one bit over the value, and room for the amplitude.
    localparam int DW = (VALUE_WIDTH + 1 > AMP_WIDTH + 1) ? VALUE_WIDTH + 2 : AMP_WIDTH + 2;

    logic signed [VALUE_WIDTH-1:0] last, prev, old;
    logic signed [DW-1:0]          amp, diff, drop, rise;
    logic                          full, rising, narrow, brk_a, brk_b;

    // Newest, previous and oldest points as seen from the count.
    assign full = (count_i == CNT_FULL);
    assign last = full ? pts_i[2] : pts_i[1];
    assign prev = full ? pts_i[1] : pts_i[0];
    assign old  = pts_i[0];

    // Signed differences at full precision.
    assign amp    = DW'($signed({1'b0, min_amp_i}));
    assign diff   = DW'(last) - DW'(prev);
    assign drop   = DW'(last) - DW'(sample_i);
    assign rise   = DW'(sample_i) - DW'(last);
    assign rising = diff > 0;
    assign narrow = (count_i == CNT_PAIR) && (diff <= amp) && (diff >= -amp);

    always_comb begin
        count_o = count_i;
        pts_o   = pts_i;
        evt_o   = '0;
        brk_a   = 1'b0;
        brk_b   = 1'b0;
        case (count_i)
            CNT_EMPTY: begin
                pts_o[0] = sample_i;
                count_o  = CNT_ONE;
            end
            CNT_ONE: begin
                // A repeat of the first value is ignored.
                if (pts_i[0] != sample_i) begin
                    pts_o[1] = sample_i;
                    count_o  = CNT_PAIR;
                end
            end
            CNT_PAIR, CNT_FULL: begin
                if (narrow) begin
                    // Two points within the amplitude: reshape the pair, or add a third point.
                    if (rising ? (last < sample_i) : (last > sample_i)) begin
                        pts_o[1] = sample_i;
                    end else if (rising ? (drop > amp) : (rise > amp)) begin
                        pts_o[2] = sample_i;
                        count_o  = CNT_FULL;
                    end else if (rising ? (prev >= sample_i) : (prev <= sample_i)) begin
                        pts_o[0] = last;
                        pts_o[1] = sample_i;
                    end
                end else if (rising ? (last < sample_i) : (last > sample_i)) begin
                    // Extend the newest point; passing the older extreme is a break.
                    if (full) begin
                        brk_a = rising ? (old >= last && old < sample_i)
                                       : (old <= last && old > sample_i);
                        pts_o[2] = sample_i;
                    end else begin
                        pts_o[1] = sample_i;
                    end
                    evt_o.valid  = brk_a;
                    evt_o.dir_up = rising;
                end else if (rising ? (drop > amp) : (rise > amp)) begin
                    // Reversal: start a new swing point, pushing out the oldest when the store is full.
                    brk_a = full && (rising ? (old > last) : (old < last));
                    brk_b = rising ? (prev > sample_i) : (prev < sample_i);
                    evt_o.valid       = brk_a | brk_b;
                    evt_o.dir_up      = !rising;
                    evt_o.double_step = brk_a & brk_b;
                    if (full) begin
                        pts_o[0] = pts_i[1];
                        pts_o[1] = pts_i[2];
                    end
                    pts_o[2] = sample_i;
                    count_o  = CNT_FULL;
                end
            end
            default: begin
                count_o = count_i;
            end
        endcase
    end

endmodule

/* design/sptt_trend_counter.sv */
// Saturating signed trend run counter, restarting at plus or minus one on a
// change of direction. Depends on sptt_pkg.
module sptt_trend_counter #(
    parameter int TREND_WIDTH = sptt_pkg::TREND_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step_en_i,
    input  sptt_pkg::trend_evt_t          evt_i,
    output logic signed [TREND_WIDTH-1:0] trend_next_o
);
    import sptt_pkg::*;

    localparam logic signed [TREND_WIDTH-1:0] TMAX = {1'b0, {(TREND_WIDTH-1){1'b1}}};
    localparam logic signed [TREND_WIDTH-1:0] TMIN = {1'b1, {(TREND_WIDTH-1){1'b0}}};
    localparam logic signed [TREND_WIDTH-1:0] ONE  = TREND_WIDTH'(1);

    logic signed [TREND_WIDTH-1:0] trend_reg, trend_next, once;

    // One count step in the given direction.
    function automatic logic signed [TREND_WIDTH-1:0] count_step(
        input logic signed [TREND_WIDTH-1:0] t,
        input logic                          up
    );
        logic signed [TREND_WIDTH-1:0] r;
        r = t;
        if (up) begin
            if (t < 0) r = ONE;
            else if (t != TMAX) r = t + ONE;
        end else begin
            if (t > 0) r = -ONE;
            else if (t != TMIN) r = t - ONE;
        end
        return r;
    endfunction

    // Apply up to two steps of the item's event.
    always_comb begin
        once       = count_step(trend_reg, evt_i.dir_up);
        trend_next = trend_reg;
        if (step_en_i && evt_i.valid) begin
            trend_next = evt_i.double_step ? count_step(once, evt_i.dir_up) : once;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trend_reg <= '0;
        end else begin
            trend_reg <= trend_next;
        end
    end

    assign trend_next_o = trend_next;

    // The counter moves only on a processed item.
    a_trend_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en_i |=> $stable(trend_reg))
        else $error("trend moved without an item");

    // A restart upward from a negative run leaves the run positive.
    a_trend_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en_i && evt_i.valid && evt_i.dir_up && trend_reg < 0) |=> trend_reg > 0)
        else $error("trend did not restart upward");

    // Any count step leaves the run away from zero.
    a_trend_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en_i && evt_i.valid) |=> trend_reg != '0)
        else $error("trend stepped to zero");

endmodule

/* design/swing_point_trend_tracker.sv */
// Top level of the swing point trend tracker: input register, swing point
// store, trend counter and result register. Depends on sptt_pkg, sptt_update
// and sptt_trend_counter.
//
//  Channel  | Direction | Handshake          | Contents
//  ---------+-----------+--------------------+-----------------------------------
//  s_       | in        | s_tvalid/s_tready  | sample_value
//  m_       | out       | m_tvalid/m_tready  | trend, points_held
//  cfg_     | in        | cfg_valid/cfg_ready| min_amp
//
// One item per cycle sustained while m_tready stays high; an accepted item passes
// through the input register to the output register, and each item's result
// depends on the store left by the one before it, updated as it is processed.
// Reset clears the point count, the trend and min_amp.
// A stalled output holds the result and the input register keeps one item;
// s_tready drops only when both are full. cfg_ready is always high.
module swing_point_trend_tracker #(
    parameter int VALUE_WIDTH = sptt_pkg::VALUE_WIDTH_DEF,
    parameter int TREND_WIDTH = sptt_pkg::TREND_WIDTH_DEF,
    parameter int IN_W  = ((VALUE_WIDTH + 7) / 8) * 8,
    parameter int OUT_W = ((TREND_WIDTH + sptt_pkg::CNT_WIDTH + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [IN_W-1:0]                s_tdata,   // [VALUE_WIDTH-1:0] sample_value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_W-1:0]               m_tdata,   // trend, then points_held
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sptt_pkg::AMP_WIDTH-1:0] cfg_data   // min_amp
);
    import sptt_pkg::*;

    logic                          in_valid_reg, in_valid_next;
    logic signed [VALUE_WIDTH-1:0] in_sample_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [TREND_WIDTH-1:0] out_trend_reg;
    logic [CNT_WIDTH-1:0]          out_count_reg;
    logic [AMP_WIDTH-1:0]          min_amp_reg;
    logic [CNT_WIDTH-1:0]          count_reg, count_next;
    logic signed [VALUE_WIDTH-1:0] pts_reg  [MAX_POINTS];
    logic signed [VALUE_WIDTH-1:0] pts_next [MAX_POINTS];
    logic signed [TREND_WIDTH-1:0] trend_next;
    trend_evt_t                    evt;
    logic                          advance, proc;

    // Flow control: the update stage moves when the result register is free.
    assign advance   = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (proc ? 1'b0 : in_valid_reg);
    assign out_valid_next = proc ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    // Next state of the swing point store.
    sptt_update #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_update (
        .sample_i  (in_sample_reg),
        .min_amp_i (min_amp_reg),
        .count_i   (count_reg),
        .pts_i     (pts_reg),
        .count_o   (count_next),
        .pts_o     (pts_next),
        .evt_o     (evt)
    );

    // Trend run counter.
    sptt_trend_counter #(
        .TREND_WIDTH (TREND_WIDTH)
    ) u_trend (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en_i    (proc),
        .evt_i        (evt),
        .trend_next_o (trend_next)
    );

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= CNT_EMPTY;
            min_amp_reg   <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (proc) begin
                count_reg <= count_next;
            end
            if (cfg_valid && cfg_ready) begin
                min_amp_reg <= cfg_data;
            end
        end
    end

    // Payload registers: input sample, swing points and result.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_sample_reg <= s_tdata[VALUE_WIDTH-1:0];
        end
        if (proc) begin
            pts_reg       <= pts_next;
            out_count_reg <= count_next;
            out_trend_reg <= (count_next < CNT_PAIR) ? '0 : trend_next;
        end
    end

    // Result packing, padded with zeros.
    always_comb begin
        m_tdata = '0;
        m_tdata[TREND_WIDTH-1:0]                   = out_trend_reg;
        m_tdata[TREND_WIDTH+CNT_WIDTH-1:TREND_WIDTH] = out_count_reg;
    end
    assign m_tvalid = out_valid_reg;

    // The point count never falls and grows by at most one per item.
    a_count_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        proc |=> (count_reg >= $past(count_reg)) &&
                 (count_reg <= $past(count_reg) + 2'd1 || $past(count_reg) == CNT_FULL))
        else $error("point count moved wrongly");

    // The count changes only on a processed item.
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !proc |=> $stable(count_reg))
        else $error("point count moved without an item");

    // A result with fewer than two points reports no trend.
    a_trend_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_count_reg < CNT_PAIR) |-> out_trend_reg == '0)
        else $error("trend reported with fewer than two points");

    // An item blocked in the input register is kept.
    a_in_keep: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("input item lost while stalled");

endmodule
